// ===== design/rdpd_pkg.sv =====
// shared types, constants and decode functions of the rotary dial pulse decoder
`timescale 1ns / 1ps
`default_nettype none
package rdpd_pkg;

	localparam int COUNT_WIDTH   = 16;
	localparam int HISTORY_DEPTH = 4;
	localparam int DEB_WIDTH     = 8;
	localparam int SIL_WIDTH     = 16;
	localparam int CFG_WIDTH     = 16;
	localparam int CMP_WIDTH     = (COUNT_WIDTH > SIL_WIDTH) ? COUNT_WIDTH : SIL_WIDTH;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [3:0] TALLY_MAX     = 4'd15;
	localparam logic [3:0] DIGIT_INVALID = 4'd15;
	localparam logic [7:0] KEY_ONE       = 8'h1E;
	localparam logic [7:0] KEY_FOUR      = 8'h21;
	localparam logic [7:0] KEY_ZERO      = 8'h27;
	localparam logic [7:0] KEY_NONE      = 8'h00;

	localparam logic [DEB_WIDTH-1:0] DEBOUNCE_RESET = 8'd5;
	localparam logic [SIL_WIDTH-1:0] SILENCE_RESET  = 16'd400;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_DEBOUNCE = 1'b0,
		CFG_SILENCE  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [DEB_WIDTH-1:0] debounce_ticks;
		logic [SIL_WIDTH-1:0] silence_ticks;
	} cfg_t;

	typedef struct packed {
		logic dial_level;
		logic on_hook;
		logic host_ready;
	} item_t;

	typedef struct packed {
		logic       report_valid;
		logic [7:0] report_key;
		logic       boot_request;
	} result_t;

	// ten pulses dial zero, one to nine dial themselves, the rest is invalid
	function automatic logic [3:0] tally_to_digit(input logic [3:0] tally);
		logic [3:0] d;
		d = DIGIT_INVALID;
		if (tally == 4'd10) begin
			d = 4'd0;
		end else if (tally <= 4'd9) begin
			d = tally;
		end
		return d;
	endfunction

	// keyboard usage of a digit, none for an invalid digit
	function automatic logic [7:0] digit_to_key(input logic [3:0] digit);
		logic [7:0] k;
		k = KEY_NONE;
		if (digit == 4'd0) begin
			k = KEY_ZERO;
		end else if (digit <= 4'd9) begin
			k = KEY_ONE + {4'd0, digit} - 8'd1;
		end
		return k;
	endfunction

endpackage
`default_nettype wire

// ===== design/rotary_dial_pulse_decoder.sv =====
// top level of the rotary dial pulse decoder: registers, handshake and configuration
//
// Each input transaction is one millisecond tick carrying the raw dial contact,
// the hook switch and host readiness; each tick yields exactly one output
// transaction with the keyboard report and the boot request. The block takes one
// transaction per clock cycle: a tick is captured in an input register, the
// whole update runs in one pass of combinational logic, and the result lands in
// the output register once that register is empty or being read.
// The output register parts the two sides, so new ticks keep flowing while a
// result waits; only a stalled output with a full input register holds in_ready
// low. Configuration writes take effect at once and belong in idle periods.
`timescale 1ns / 1ps
`default_nettype none
module rotary_dial_pulse_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// tick channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          dial_level,
	input  wire logic                          on_hook,
	input  wire logic                          host_ready,
	// report channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               report_valid,
	output logic [7:0]                         report_key,
	output logic                               boot_request,
	// configuration write port
	input  wire logic                          cfg_wr_en,
	input  wire logic [0:0]                    cfg_index,
	input  wire logic [rdpd_pkg::CFG_WIDTH-1:0] cfg_data
);

	rdpd_pkg::cfg_t    cfg_q;
	rdpd_pkg::item_t   item_s1;
	logic              valid_s1;
	rdpd_pkg::result_t result_c;
	rdpd_pkg::result_t result_s2;
	logic              valid_s2;
	logic              advance;
	logic              step;
	logic              load_s1;

	// handshake
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign load_s1  = in_valid && in_ready;
	assign step     = valid_s1 && advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= rdpd_pkg::DEBOUNCE_RESET;
			cfg_q.silence_ticks  <= rdpd_pkg::SILENCE_RESET;
		end else if (cfg_wr_en) begin
			case (rdpd_pkg::cfg_reg_t'(cfg_index))
				rdpd_pkg::CFG_DEBOUNCE: begin
					cfg_q.debounce_ticks <= cfg_data[rdpd_pkg::DEB_WIDTH-1:0];
				end
				rdpd_pkg::CFG_SILENCE: begin
					cfg_q.silence_ticks <= cfg_data[rdpd_pkg::SIL_WIDTH-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.dial_level <= dial_level;
			item_s1.on_hook    <= on_hook;
			item_s1.host_ready <= host_ready;
		end
	end

	// tick update
	rdpd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg_q),
		.item   (item_s1),
		.result (result_c)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result_c;
		end
	end

	assign out_valid    = valid_s2;
	assign report_valid = result_s2.report_valid;
	assign report_key   = result_s2.report_key;
	assign boot_request = result_s2.boot_request;

endmodule
`default_nettype wire

// ===== design/rdpd_core.sv =====
// dial state and the single-pass update for one tick
`timescale 1ns / 1ps
`default_nettype none
module rdpd_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire rdpd_pkg::cfg_t   cfg,
	input  wire rdpd_pkg::item_t  item,
	output rdpd_pkg::result_t     result
);

	logic                             raw_q, raw_n;
	logic                             stable_q, stable_n;
	logic [rdpd_pkg::COUNT_WIDTH-1:0] settle_q, settle_n;
	logic [rdpd_pkg::COUNT_WIDTH-1:0] quiet_q, quiet_n;
	logic [3:0]                       tally_q, tally_n;
	logic [3:0]                       hist_q [rdpd_pkg::HISTORY_DEPTH];
	logic [3:0]                       hist_n [rdpd_pkg::HISTORY_DEPTH];
	logic                             pending_q, pending_n;
	logic                             down_q, down_n;
	logic [7:0]                       key_q, key_n;
	logic                             accept_lvl;
	logic                             finish;
	logic [3:0]                       digit;
	logic [rdpd_pkg::CMP_WIDTH-1:0]   quiet_ext, silence_ext;

	// next state and result of one tick
	always_comb begin
		raw_n     = raw_q;
		stable_n  = stable_q;
		settle_n  = settle_q;
		tally_n   = tally_q;
		hist_n    = hist_q;
		pending_n = pending_q;
		down_n    = down_q;
		key_n     = key_q;
		result    = '0;
		accept_lvl = 1'b0;
		finish     = 1'b0;
		digit      = rdpd_pkg::DIGIT_INVALID;
		quiet_n    = (quiet_q == rdpd_pkg::COUNT_MAX) ? quiet_q : quiet_q + 1'b1;
		quiet_ext   = '0;
		silence_ext = '0;

		if (item.on_hook) begin
			// hung up: time passes, dialling is dropped
			settle_n  = (settle_q == rdpd_pkg::COUNT_MAX) ? settle_q : settle_q + 1'b1;
			tally_n   = 4'd0;
			pending_n = 1'b0;
			down_n    = 1'b0;
		end else begin
			// debounce the raw contact
			if (item.dial_level != raw_q) begin
				raw_n    = item.dial_level;
				settle_n = '0;
			end else begin
				settle_n = (settle_q == rdpd_pkg::COUNT_MAX) ? settle_q : settle_q + 1'b1;
			end
			accept_lvl = (settle_n >= rdpd_pkg::COUNT_WIDTH'(cfg.debounce_ticks))
				&& (raw_n != stable_q);
			if (accept_lvl) begin
				stable_n = raw_n;
				quiet_n  = '0;
				if (!raw_n && tally_q != rdpd_pkg::TALLY_MAX) begin
					tally_n = tally_q + 4'd1;
				end
			end

			// end of digit after the silence time
			quiet_ext   = rdpd_pkg::CMP_WIDTH'(quiet_n);
			silence_ext = rdpd_pkg::CMP_WIDTH'(cfg.silence_ticks);
			finish = !pending_q && tally_n != 4'd0 && quiet_ext > silence_ext;
			if (finish) begin
				digit = rdpd_pkg::tally_to_digit(tally_n);
				tally_n = 4'd0;
				for (int i = 0; i < rdpd_pkg::HISTORY_DEPTH - 1; i++) begin
					hist_n[i] = hist_q[i+1];
				end
				hist_n[rdpd_pkg::HISTORY_DEPTH-1] = digit;
				result.boot_request = hist_n[rdpd_pkg::HISTORY_DEPTH-4] == 4'd1
					&& hist_n[rdpd_pkg::HISTORY_DEPTH-3] == 4'd2
					&& hist_n[rdpd_pkg::HISTORY_DEPTH-2] == 4'd3
					&& hist_n[rdpd_pkg::HISTORY_DEPTH-1] == 4'd4;
				key_n = rdpd_pkg::digit_to_key(digit);
				if (key_n != rdpd_pkg::KEY_NONE) begin
					pending_n = 1'b1;
				end
			end

			// press, then release on a later ready tick
			if (pending_n && item.host_ready) begin
				result.report_valid = 1'b1;
				if (!down_q) begin
					result.report_key = key_n;
					down_n = 1'b1;
				end else begin
					down_n    = 1'b0;
					pending_n = 1'b0;
				end
			end
		end
	end

	// dial state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q     <= 1'b1;
			stable_q  <= 1'b1;
			settle_q  <= '0;
			quiet_q   <= '0;
			tally_q   <= 4'd0;
			pending_q <= 1'b0;
			down_q    <= 1'b0;
			key_q     <= rdpd_pkg::KEY_NONE;
			for (int i = 0; i < rdpd_pkg::HISTORY_DEPTH; i++) begin
				hist_q[i] <= rdpd_pkg::DIGIT_INVALID;
			end
		end else if (step) begin
			raw_q     <= raw_n;
			stable_q  <= stable_n;
			settle_q  <= settle_n;
			quiet_q   <= quiet_n;
			tally_q   <= tally_n;
			pending_q <= pending_n;
			down_q    <= down_n;
			key_q     <= key_n;
			hist_q    <= hist_n;
		end
	end

endmodule
`default_nettype wire

// ===== design/rdpd_checker.sv =====
// port-level checks of the rotary dial pulse decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module rdpd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       report_valid,
	input wire logic [7:0] report_key,
	input wire logic       boot_request
);

	// a stalled report transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(report_key)
			&& $stable(report_valid) && $stable(boot_request))
		else $error("report transaction changed while stalled");

	// no key without a report
	a_key_needs_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !report_valid |-> report_key == rdpd_pkg::KEY_NONE)
		else $error("key code without report");

	// press reports carry digit keys only
	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report_key != rdpd_pkg::KEY_NONE |->
			report_key >= rdpd_pkg::KEY_ONE && report_key <= rdpd_pkg::KEY_ZERO)
		else $error("press report with a non-digit key");

	// the digit that completes the boot sequence is pressed at once if reported
	a_boot_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && boot_request && report_valid |-> report_key == rdpd_pkg::KEY_FOUR)
		else $error("boot request with a wrong key report");

endmodule

bind rotary_dial_pulse_decoder rdpd_checker u_rdpd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.report_valid (report_valid),
	.report_key   (report_key),
	.boot_request (boot_request)
);
`default_nettype wire

// ===== test/tb_rotary_dial_pulse_decoder.sv =====
// self-checking testbench of the rotary dial pulse decoder with its report scoreboard
`timescale 1ns / 1ps

// mirrors the decoder state and queues the report expected for every tick
class dial_scoreboard;
	logic [rdpd_pkg::DEB_WIDTH-1:0]   debounce_cfg;
	logic [rdpd_pkg::SIL_WIDTH-1:0]   silence_cfg;
	logic                             last_raw;
	logic                             settled_level;
	logic [rdpd_pkg::COUNT_WIDTH-1:0] raw_age;
	logic [rdpd_pkg::COUNT_WIDTH-1:0] quiet_age;
	logic [3:0]                       pulses;
	logic [3:0]                       recent_digits [rdpd_pkg::HISTORY_DEPTH];
	logic                             key_queued;
	logic                             press_sent;
	logic [7:0]                       queued_key;
	rdpd_pkg::result_t                expected_reports [$];
	int unsigned                      errors;
	int unsigned                      ticks;
	int unsigned                      digits;
	int unsigned                      reports;
	int unsigned                      boots;

	function new();
		debounce_cfg  = rdpd_pkg::DEBOUNCE_RESET;
		silence_cfg   = rdpd_pkg::SILENCE_RESET;
		last_raw      = 1'b1;
		settled_level = 1'b1;
		raw_age       = '0;
		quiet_age     = '0;
		pulses        = '0;
		foreach (recent_digits[i]) recent_digits[i] = rdpd_pkg::DIGIT_INVALID;
		key_queued    = 1'b0;
		press_sent    = 1'b0;
		queued_key    = rdpd_pkg::KEY_NONE;
		errors        = 0;
		ticks         = 0;
		digits        = 0;
		reports       = 0;
		boots         = 0;
	endfunction

	// saturating tick counter
	function logic [rdpd_pkg::COUNT_WIDTH-1:0] age_up(
		input logic [rdpd_pkg::COUNT_WIDTH-1:0] c);
		return (c == rdpd_pkg::COUNT_MAX) ? c : c + 1'b1;
	endfunction

	// advance the model by one accepted tick and queue its report
	function void note_tick(input logic level, input logic hook, input logic ready);
		rdpd_pkg::result_t r;
		logic [3:0]        digit;
		r = '0;
		ticks++;
		quiet_age = age_up(quiet_age);
		if (hook) begin
			// hung up: time still passes, dialling is dropped
			raw_age    = age_up(raw_age);
			pulses     = '0;
			key_queued = 1'b0;
			press_sent = 1'b0;
		end else begin
			// debounce the raw contact
			if (level != last_raw) begin
				last_raw = level;
				raw_age  = '0;
			end else begin
				raw_age = age_up(raw_age);
			end
			if (raw_age >= debounce_cfg && last_raw != settled_level) begin
				settled_level = last_raw;
				quiet_age     = '0;
				if (!settled_level && pulses != rdpd_pkg::TALLY_MAX) begin
					pulses = pulses + 4'd1;
				end
			end
			// end of a digit after enough silence
			if (!key_queued && pulses != 4'd0 && quiet_age > silence_cfg) begin
				digits++;
				if (pulses == 4'd10) begin
					digit = 4'd0;
				end else if (pulses <= 4'd9) begin
					digit = pulses;
				end else begin
					digit = rdpd_pkg::DIGIT_INVALID;
				end
				pulses = '0;
				for (int i = 0; i < rdpd_pkg::HISTORY_DEPTH - 1; i++) begin
					recent_digits[i] = recent_digits[i + 1];
				end
				recent_digits[rdpd_pkg::HISTORY_DEPTH - 1] = digit;
				if (recent_digits[0] == 4'd1 && recent_digits[1] == 4'd2 &&
				    recent_digits[2] == 4'd3 && recent_digits[3] == 4'd4) begin
					r.boot_request = 1'b1;
					boots++;
				end
				if (digit == 4'd0) begin
					queued_key = rdpd_pkg::KEY_ZERO;
				end else if (digit <= 4'd9) begin
					queued_key = rdpd_pkg::KEY_ONE + {4'd0, digit} - 8'd1;
				end else begin
					queued_key = rdpd_pkg::KEY_NONE;
				end
				key_queued = (queued_key != rdpd_pkg::KEY_NONE);
			end
			// press report, then release report
			if (key_queued && ready) begin
				r.report_valid = 1'b1;
				reports++;
				if (!press_sent) begin
					r.report_key = queued_key;
					press_sent   = 1'b1;
				end else begin
					r.report_key = rdpd_pkg::KEY_NONE;
					press_sent   = 1'b0;
					key_queued   = 1'b0;
				end
			end
		end
		expected_reports.push_back(r);
	endfunction

	// compare one output transaction with the oldest expectation
	function void check_report(input logic valid, input logic [7:0] key, input logic boot);
		rdpd_pkg::result_t want;
		if (expected_reports.size() == 0) begin
			$error("unexpected output transaction: report_valid %0d report_key %h %s %0d",
				valid, key, "boot_request", boot);
			errors++;
		end else begin
			want = expected_reports.pop_front();
			if (valid !== want.report_valid) begin
				$error("report_valid: expected %0d, actual %0d", want.report_valid, valid);
				errors++;
			end
			if (key !== want.report_key) begin
				$error("report_key: expected %h, actual %h", want.report_key, key);
				errors++;
			end
			if (boot !== want.boot_request) begin
				$error("boot_request: expected %0d, actual %0d", want.boot_request, boot);
				errors++;
			end
		end
	endfunction
endclass

module tb_rotary_dial_pulse_decoder;

	localparam int unsigned CYCLE_LIMIT  = 2_000_000;
	localparam int unsigned RANDOM_TICKS = 300;
	localparam int unsigned DRAIN_CYCLES = 10;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic                           dial_level;
	logic                           on_hook;
	logic                           host_ready;
	logic                           out_valid;
	logic                           out_ready;
	logic                           report_valid;
	logic [7:0]                     report_key;
	logic                           boot_request;
	logic                           cfg_wr_en;
	logic [0:0]                     cfg_index;
	logic [rdpd_pkg::CFG_WIDTH-1:0] cfg_data;

	dial_scoreboard sb = new();
	bit             tx_gaps;
	bit             rx_stalls;
	int unsigned    cycle_count;
	int unsigned    settings;

	rotary_dial_pulse_decoder uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.dial_level  (dial_level),
		.on_hook     (on_hook),
		.host_ready  (host_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.report_valid(report_valid),
		.report_key  (report_key),
		.boot_request(boot_request),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// report side: random stalls, check every output transaction
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = !(rx_stalls && $urandom_range(0, 99) < 37);
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_report(report_valid, report_key, boot_request);
			end
		end
	end

	function automatic bit chance(input int unsigned pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// one tick transaction, with a random gap ahead of it
	task automatic send_tick(input logic lvl, input logic hook, input logic rdy);
		while (tx_gaps && $urandom_range(0, 99) < 37) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		dial_level = lvl;
		on_hook    = hook;
		host_ready = rdy;
		do @(posedge clk); while (!in_ready);
		sb.note_tick(lvl, hook, rdy);
		@(negedge clk);
	endtask

	task automatic hold_level(input logic lvl, input int unsigned n, input int unsigned ready_pct);
		repeat (n) send_tick(lvl, 1'b0, chance(ready_pct));
	endtask

	// a well-formed digit: pulses, with short bounce unless tight, silence, then room for press and release
	task automatic dial_digit(input int unsigned count, input bit tight,
		input int unsigned ready_pct);
		int unsigned hold;
		hold = sb.debounce_cfg + 1;
		for (int i = 0; i < count; i++) begin
			if (!tight && sb.debounce_cfg > 1 && chance(25)) begin
				// contact bounce shorter than the debounce time
				send_tick(1'b0, 1'b0, chance(ready_pct));
				send_tick(1'b1, 1'b0, chance(ready_pct));
			end
			hold_level(1'b0, hold + (tight ? 0 : $urandom_range(0, 2)), ready_pct);
			hold_level(1'b1, hold + (tight ? 0 : $urandom_range(0, 2)), ready_pct);
		end
		hold_level(1'b1, sb.silence_cfg + 1 + (tight ? 0 : $urandom_range(1, 3)), ready_pct);
		hold_level(1'b1, tight ? 1 : 2 + $urandom_range(0, 3), tight ? ready_pct : 90);
	endtask

	// register write once every expected report has come back
	task automatic write_reg(input rdpd_pkg::cfg_reg_t idx,
		input logic [rdpd_pkg::CFG_WIDTH-1:0] value);
		in_valid = 1'b0;
		while (sb.expected_reports.size() != 0) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == rdpd_pkg::CFG_DEBOUNCE) begin
			sb.debounce_cfg = value[rdpd_pkg::DEB_WIDTH-1:0];
		end else begin
			sb.silence_cfg = value[rdpd_pkg::SIL_WIDTH-1:0];
		end
	endtask

	task automatic configure(input logic [rdpd_pkg::DEB_WIDTH-1:0] deb,
		input logic [rdpd_pkg::SIL_WIDTH-1:0] sil);
		write_reg(rdpd_pkg::CFG_DEBOUNCE,
			{{(rdpd_pkg::CFG_WIDTH-rdpd_pkg::DEB_WIDTH){1'b0}}, deb});
		write_reg(rdpd_pkg::CFG_SILENCE, sil);
		settings++;
	endtask

	// stimulus
	initial begin
		int unsigned random_end;
		int unsigned pick;
		int unsigned count;
		logic [rdpd_pkg::DEB_WIDTH-1:0] deb;
		logic [rdpd_pkg::SIL_WIDTH-1:0] sil;

		in_valid   = 1'b0;
		dial_level = 1'b1;
		on_hook    = 1'b0;
		host_ready = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = rdpd_pkg::CFG_DEBOUNCE;
		cfg_data   = '0;
		tx_gaps    = 1'b1;
		rx_stalls  = 1'b1;
		settings   = 1;
		arst_n     = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every field combination under the reset settings, on hook included
		for (int combo = 0; combo < 8; combo++) begin
			send_tick(combo[2], combo[1], combo[0]);
		end
		// zero debounce: a digit whose key waits for the host
		configure(8'd0, 16'd1);
		dial_digit(2, 1'b1, 0);
		send_tick(1'b1, 1'b0, 1'b0);
		send_tick(1'b1, 1'b0, 1'b1);
		send_tick(1'b1, 1'b0, 1'b1);
		// hang up in the middle of a digit
		send_tick(1'b0, 1'b0, 1'b1);
		send_tick(1'b1, 1'b0, 1'b1);
		send_tick(1'b1, 1'b1, 1'b1);
		send_tick(1'b1, 1'b0, 1'b1);

		// random phases of dialling, aborts and noise under varied settings
		random_end = sb.ticks + RANDOM_TICKS;
		while (sb.ticks < random_end) begin
			pick = $urandom_range(0, 9);
			deb  = (pick == 0) ? 8'd0 : (pick < 8) ? 8'($urandom_range(1, 3)) :
			       (pick == 8) ? 8'($urandom_range(4, 10)) : 8'd1;
			pick = $urandom_range(0, 9);
			sil  = (pick < 7) ? 16'($urandom_range(1, 16)) :
			       (pick < 9) ? 16'($urandom_range(17, 60)) : 16'd1;
			configure(deb, sil);
			tx_gaps   = chance(80);
			rx_stalls = chance(80);
			repeat ($urandom_range(2, 6)) begin
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					// the boot sequence
					for (int d = 1; d <= 4; d++) dial_digit(d, 1'b0, 75);
				end else if (pick < 60) begin
					pick  = $urandom_range(0, 9);
					count = (pick < 6) ? $urandom_range(1, 9) :
					        (pick < 8) ? 10 : $urandom_range(11, 16);
					dial_digit(count, 1'b0, 75);
				end else if (pick < 75) begin
					// partial digit, then the handset goes down
					repeat ($urandom_range(1, 4)) begin
						hold_level(1'b0, sb.debounce_cfg + 1, 75);
						hold_level(1'b1, sb.debounce_cfg + 1, 75);
					end
					repeat ($urandom_range(1, 5)) begin
						send_tick(chance(50), 1'b1, chance(50));
					end
					hold_level(1'b1, sb.debounce_cfg + 2, 75);
				end else begin
					repeat ($urandom_range(5, 30)) begin
						send_tick(chance(50), chance(10), chance(60));
					end
				end
			end
		end

		// reset settings
		configure(rdpd_pkg::DEBOUNCE_RESET, rdpd_pkg::SILENCE_RESET);
		dial_digit(1, 1'b0, 75);

		// longest debounce, with neither side idling
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		configure(8'hFF, 16'd1);
		dial_digit(1, 1'b0, 75);

		// longest silence holds the digit back until the silence time is shortened
		configure(8'd2, 16'hFFFF);
		repeat (2) begin
			hold_level(1'b0, 3, 75);
			hold_level(1'b1, 3, 75);
		end
		hold_level(1'b1, 100, 75);
		write_reg(rdpd_pkg::CFG_SILENCE, 16'd50);
		hold_level(1'b1, 4, 100);

		// drain
		in_valid = 1'b0;
		while (sb.expected_reports.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d ticks over %0d settings: %0d digits, %0d reports, %0d boots",
			sb.ticks, settings, sb.digits, sb.reports, sb.boots);
		$display("mismatches found: %0d", sb.errors);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
design/rdpd_pkg.sv
design/rdpd_core.sv
design/rotary_dial_pulse_decoder.sv
design/rdpd_checker.sv
test/tb_rotary_dial_pulse_decoder.sv
